>>> rtl/depth_pixel_backprojection_defines.svh
// assertion macros for the depth pixel back-projection checker
// expects clk and rst_n in the scope of each use
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// same-cycle implication, off during reset
`define DPB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define DPB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition that must follow a cycle in reset
`define DPB_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/dpb_pkg.sv
// shared types, constants and fixed-point helpers for depth pixel back-projection
// no dependencies
`default_nettype none

package dpb_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int ADDR_W          = 6;
    localparam int CFG_W           = 64;
    localparam int OUT_BITS        = 309;
    localparam int OUT_W           = ((OUT_BITS + 7) / 8) * 8;
    localparam int QMUL_LAT        = 4;

    localparam logic [15:0] DEPTH_MIN_EXCL = 16'd800;
    localparam logic [15:0] DEPTH_MAX_EXCL = 16'd60000;

    localparam logic [23:0] INV_FX_RST = 24'd31957;
    localparam logic [23:0] INV_FY_RST = 24'd31957;
    localparam logic [15:0] CX_RST     = 16'd5112;
    localparam logic [15:0] CY_RST     = 16'd3832;
    localparam logic [23:0] DSCALE_RST = 24'd3355;

    localparam logic [7:0] FIXED_RED   = 8'd255;
    localparam logic [7:0] FIXED_GREEN = 8'd255;
    localparam logic [7:0] FIXED_BLUE  = 8'd0;

    localparam int MODE_COLOR = 0;
    localparam int MODE_COV   = 1;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_INV_FX   = 3'd0,
        REG_INV_FY   = 3'd1,
        REG_CX       = 3'd2,
        REG_CY       = 3'd3,
        REG_DSCALE   = 3'd4,
        REG_PVAR     = 3'd5,
        REG_DCOEF    = 3'd6,
        REG_MODE     = 3'd7
    } reg_index_t;

    // saturating add to +-(2^63-1)
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SMAX))
            return SMAX;
        else if (s < -65'(SMAX))
            return -SMAX;
        else
            return s[63:0];
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [30:0] sat_u31(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 31'h7FFF_FFFF;
        else if (v < 64'sd0)
            return 31'd0;
        else
            return v[30:0];
    endfunction

    // signed q4.12 coefficient scaled to q.16
    function automatic logic signed [63:0] coef64(input logic [15:0] c);
        return {{44{c[15]}}, c, 4'b0000};
    endfunction

endpackage

`default_nettype wire

>>> rtl/dpb_qmul.sv
// pipelined signed 64x64 multiply, round half away from zero by 2^SHIFT, saturate
// built from four 32x32 partial products; uses dpb_pkg
`default_nettype none

module dpb_qmul #(
    parameter int SHIFT = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    import dpb_pkg::*;

    logic         neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg;
    logic [128:0] rounded;
    logic [128:0] shifted;
    logic [63:0]  mag;
    logic signed [63:0] p_reg;

    always_comb
    begin
        rounded = {1'b0, prod_reg} + (129'd1 << (SHIFT - 1));
        shifted = rounded >> SHIFT;
        if (shifted > 129'(SMAX))
            mag = 64'(SMAX);
        else
            mag = shifted[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[63] ^ b[63];
            ma_reg   <= a[63] ? 64'(-a) : 64'(a);
            mb_reg   <= b[63] ? 64'(-b) : 64'(b);

            neg2_reg <= neg1_reg;
            p00_reg  <= ma_reg[31:0]  * mb_reg[31:0];
            p01_reg  <= ma_reg[31:0]  * mb_reg[63:32];
            p10_reg  <= ma_reg[63:32] * mb_reg[31:0];
            p11_reg  <= ma_reg[63:32] * mb_reg[63:32];

            neg3_reg <= neg2_reg;
            prod_reg <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                      + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};

            p_reg    <= neg3_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/depth_pixel_backprojection.sv
// an accepted pixel passes through the stage registers into the output register
// throughput: one pixel per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a held output stalls every stage
// pixels with out-of-range depth drop at the first stage as empty slots
// reset (async, active low) empties the pipeline and loads register defaults
`default_nettype none

module depth_pixel_backprojection #(
    parameter int COORD_WIDTH = dpb_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // apb configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dpb_pkg::ADDR_W-1:0]       paddr,
    input  logic [dpb_pkg::CFG_W-1:0]        pwdata,
    output logic [dpb_pkg::CFG_W-1:0]        prdata,
    output logic                             pready,
    // pixels: column, row, depth_raw, red, green, blue (low to high)
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((2*COORD_WIDTH+40+7)/8)*8-1:0] s_tdata,
    // points: point_x, point_y, point_z, out_red, out_green, out_blue,
    // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz (low to high)
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dpb_pkg::OUT_W-1:0]        m_tdata
);
    import dpb_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = ((CW + 4 > 16) ? CW + 4 : 16) + 1;
    localparam int NS = 20;

    // configuration registers
    logic [23:0] inv_fx_reg, inv_fy_reg, dscale_reg;
    logic [15:0] cx_reg, cy_reg;
    logic [63:0] pvar_reg, dcoef_reg;
    logic [1:0]  mode_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_fx_reg <= INV_FX_RST;
            inv_fy_reg <= INV_FY_RST;
            cx_reg     <= CX_RST;
            cy_reg     <= CY_RST;
            dscale_reg <= DSCALE_RST;
            pvar_reg   <= '0;
            dcoef_reg  <= '0;
            mode_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(paddr[5:3]))
                REG_INV_FX: inv_fx_reg <= pwdata[23:0];
                REG_INV_FY: inv_fy_reg <= pwdata[23:0];
                REG_CX:     cx_reg     <= pwdata[15:0];
                REG_CY:     cy_reg     <= pwdata[15:0];
                REG_DSCALE: dscale_reg <= pwdata[23:0];
                REG_PVAR:   pvar_reg   <= pwdata;
                REG_DCOEF:  dcoef_reg  <= pwdata;
                REG_MODE:   mode_reg   <= pwdata[1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[5:3]))
            REG_INV_FX: prdata = 64'(inv_fx_reg);
            REG_INV_FY: prdata = 64'(inv_fy_reg);
            REG_CX:     prdata = 64'(cx_reg);
            REG_CY:     prdata = 64'(cy_reg);
            REG_DSCALE: prdata = 64'(dscale_reg);
            REG_PVAR:   prdata = pvar_reg;
            REG_DCOEF:  prdata = dcoef_reg;
            REG_MODE:   prdata = 64'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    // pipeline advance
    logic adv;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // input fields
    logic [CW-1:0] u_in, v_in;
    logic [15:0]   d_in;
    logic [23:0]   rgb_in;
    logic          depth_ok;
    logic [39:0]   zprod;

    assign u_in     = s_tdata[CW-1:0];
    assign v_in     = s_tdata[2*CW-1:CW];
    assign d_in     = s_tdata[2*CW+15:2*CW];
    assign rgb_in   = s_tdata[2*CW+39:2*CW+16];
    assign depth_ok = (d_in > DEPTH_MIN_EXCL) && (d_in < DEPTH_MAX_EXCL);
    assign zprod    = 40'(d_in * dscale_reg) + 40'd128;

    // stage lines
    logic                v_reg   [1:NS];
    logic [31:0]         z_reg   [1:NS];
    logic [23:0]         rgb_reg [1:NS];
    logic signed [DW-1:0] du_reg, dv_reg;
    logic signed [63:0]  au_reg  [6:16];
    logic signed [63:0]  av_reg  [6:16];
    logic signed [63:0]  aa_reg  [10:16];
    logic signed [63:0]  ab_reg  [10:16];
    logic signed [63:0]  bb_reg  [10:16];
    logic signed [63:0]  x_reg   [10:NS];
    logic signed [63:0]  y_reg   [10:NS];
    logic signed [63:0]  ax_reg  [14:NS];
    logic signed [63:0]  ay_reg  [14:NS];
    logic signed [63:0]  sd_reg  [16:NS];
    logic signed [63:0]  s2_reg, s1_reg;

    // multiplier outputs
    logic signed [63:0] au_q, av_q, gx_q, gy_q, p2_q;
    logic signed [63:0] x_q, y_q, gxx_q, gyy_q, aa_q, ab_q, bb_q;
    logic signed [63:0] p1_q, p0_q, ax_q, ay_q;
    logic signed [63:0] bxx_q, bxy_q, byy_q, bxz_q, byz_q;

    logic signed [63:0] z1_s, z5_s, z6_s, z11_s;
    assign z1_s  = $signed({32'd0, z_reg[1]});
    assign z5_s  = $signed({32'd0, z_reg[5]});
    assign z6_s  = $signed({32'd0, z_reg[6]});
    assign z11_s = $signed({32'd0, z_reg[11]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
                v_reg[k] <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[1] <= s_tvalid && depth_ok;
            for (int k = 2; k <= NS; k++)
                v_reg[k] <= v_reg[k-1];
            m_tvalid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg[1]   <= zprod[39:8];
            rgb_reg[1] <= rgb_in;
            du_reg     <= $signed(DW'({u_in, 4'b0000})) - $signed(DW'(cx_reg));
            dv_reg     <= $signed(DW'({v_in, 4'b0000})) - $signed(DW'(cy_reg));
            for (int k = 2; k <= NS; k++)
            begin
                z_reg[k]   <= z_reg[k-1];
                rgb_reg[k] <= rgb_reg[k-1];
            end

            au_reg[6] <= au_q;
            av_reg[6] <= av_q;
            for (int k = 7; k <= 16; k++)
            begin
                au_reg[k] <= au_reg[k-1];
                av_reg[k] <= av_reg[k-1];
            end

            aa_reg[10] <= aa_q;
            ab_reg[10] <= ab_q;
            bb_reg[10] <= bb_q;
            for (int k = 11; k <= 16; k++)
            begin
                aa_reg[k] <= aa_reg[k-1];
                ab_reg[k] <= ab_reg[k-1];
                bb_reg[k] <= bb_reg[k-1];
            end

            x_reg[10] <= x_q;
            y_reg[10] <= y_q;
            for (int k = 11; k <= NS; k++)
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
            end

            ax_reg[14] <= ax_q;
            ay_reg[14] <= ay_q;
            for (int k = 15; k <= NS; k++)
            begin
                ax_reg[k] <= ax_reg[k-1];
                ay_reg[k] <= ay_reg[k-1];
            end

            // horner steps of the depth variance cubic
            s2_reg    <= sadd(p2_q, coef64(dcoef_reg[47:32]));
            s1_reg    <= sadd(p1_q, coef64(dcoef_reg[31:16]));
            sd_reg[16] <= sadd(p0_q, coef64(dcoef_reg[15:0]));
            for (int k = 17; k <= NS; k++)
                sd_reg[k] <= sd_reg[k-1];

            m_tdata_reg <= m_tdata_next;
        end
    end

    // stage 1 -> 5
    dpb_qmul #(.SHIFT(12)) u_au (.clk(clk), .en(adv), .a(64'(du_reg)),
        .b($signed({40'd0, inv_fx_reg})), .p(au_q));
    dpb_qmul #(.SHIFT(12)) u_av (.clk(clk), .en(adv), .a(64'(dv_reg)),
        .b($signed({40'd0, inv_fy_reg})), .p(av_q));
    dpb_qmul #(.SHIFT(24)) u_gx (.clk(clk), .en(adv), .a(z1_s),
        .b($signed({40'd0, inv_fx_reg})), .p(gx_q));
    dpb_qmul #(.SHIFT(24)) u_gy (.clk(clk), .en(adv), .a(z1_s),
        .b($signed({40'd0, inv_fy_reg})), .p(gy_q));
    dpb_qmul #(.SHIFT(16)) u_p2 (.clk(clk), .en(adv), .a(coef64(dcoef_reg[63:48])),
        .b(z1_s), .p(p2_q));

    // stage 5 -> 9
    dpb_qmul #(.SHIFT(16)) u_x   (.clk(clk), .en(adv), .a(z5_s), .b(au_q), .p(x_q));
    dpb_qmul #(.SHIFT(16)) u_y   (.clk(clk), .en(adv), .a(z5_s), .b(av_q), .p(y_q));
    dpb_qmul #(.SHIFT(16)) u_gxx (.clk(clk), .en(adv), .a(gx_q), .b(gx_q), .p(gxx_q));
    dpb_qmul #(.SHIFT(16)) u_gyy (.clk(clk), .en(adv), .a(gy_q), .b(gy_q), .p(gyy_q));
    dpb_qmul #(.SHIFT(16)) u_aa  (.clk(clk), .en(adv), .a(au_q), .b(au_q), .p(aa_q));
    dpb_qmul #(.SHIFT(16)) u_ab  (.clk(clk), .en(adv), .a(au_q), .b(av_q), .p(ab_q));
    dpb_qmul #(.SHIFT(16)) u_bb  (.clk(clk), .en(adv), .a(av_q), .b(av_q), .p(bb_q));

    // horner: stage 6 -> 10, stage 11 -> 15
    dpb_qmul #(.SHIFT(16)) u_p1 (.clk(clk), .en(adv), .a(s2_reg), .b(z6_s), .p(p1_q));
    dpb_qmul #(.SHIFT(16)) u_p0 (.clk(clk), .en(adv), .a(s1_reg), .b(z11_s), .p(p0_q));

    // stage 9 -> 13
    dpb_qmul #(.SHIFT(16)) u_ax (.clk(clk), .en(adv), .a(gxx_q),
        .b($signed({32'd0, pvar_reg[31:0]})), .p(ax_q));
    dpb_qmul #(.SHIFT(16)) u_ay (.clk(clk), .en(adv), .a(gyy_q),
        .b($signed({32'd0, pvar_reg[63:32]})), .p(ay_q));

    // stage 16 -> 20
    dpb_qmul #(.SHIFT(16)) u_bxx (.clk(clk), .en(adv), .a(aa_reg[16]), .b(sd_reg[16]),
        .p(bxx_q));
    dpb_qmul #(.SHIFT(16)) u_bxy (.clk(clk), .en(adv), .a(ab_reg[16]), .b(sd_reg[16]),
        .p(bxy_q));
    dpb_qmul #(.SHIFT(16)) u_byy (.clk(clk), .en(adv), .a(bb_reg[16]), .b(sd_reg[16]),
        .p(byy_q));
    dpb_qmul #(.SHIFT(16)) u_bxz (.clk(clk), .en(adv), .a(au_reg[16]), .b(sd_reg[16]),
        .p(bxz_q));
    dpb_qmul #(.SHIFT(16)) u_byz (.clk(clk), .en(adv), .a(av_reg[16]), .b(sd_reg[16]),
        .p(byz_q));

    // output formatting
    logic [30:0] cxx, cyy, pz;
    logic [31:0] cxy, cxz, cyz, czz;
    logic [23:0] rgb_out;

    always_comb
    begin
        pz = sat_u31($signed({32'd0, z_reg[NS]}));
        if (mode_reg[MODE_COLOR])
            rgb_out = rgb_reg[NS];
        else
            rgb_out = {FIXED_BLUE, FIXED_GREEN, FIXED_RED};
        if (mode_reg[MODE_COV])
        begin
            cxx = sat_u31(sadd(ax_reg[NS], bxx_q));
            cyy = sat_u31(sadd(ay_reg[NS], byy_q));
            cxy = sat_s32(bxy_q);
            cxz = sat_s32(bxz_q);
            cyz = sat_s32(byz_q);
            czz = sat_s32(sd_reg[NS]);
        end
        else
        begin
            cxx = '0;
            cyy = '0;
            cxy = '0;
            cxz = '0;
            cyz = '0;
            czz = '0;
        end
        m_tdata_next = {(OUT_W - OUT_BITS)'(0), czz, cyz, cyy, cxz, cxy, cxx, rgb_out, pz,
                        sat_s32(y_reg[NS]), sat_s32(x_reg[NS])};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/dpb_checker.sv
// port-level checks for depth_pixel_backprojection, bound to the top level
// uses dpb_pkg and depth_pixel_backprojection_defines.svh
`default_nettype none
`include "depth_pixel_backprojection_defines.svh"

module dpb_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [dpb_pkg::OUT_W-1:0] m_tdata
);
    import dpb_pkg::*;

    // a held point keeps its value
    `DPB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // input side opens exactly when the output slot frees
    `DPB_ASSERT_IMPL(a_ready_link, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))
    // reset empties the pipeline
    `DPB_ASSERT_RESET(a_reset_empty, !m_tvalid)

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

`default_nettype wire
